// ===== rtl/small_matrix_inverse_top_assert.svh =====
// Assertion macros for the small matrix inverse block.
`ifndef SMALL_MATRIX_INVERSE_TOP_ASSERT_SVH
`define SMALL_MATRIX_INVERSE_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SMI_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Implication checked in the next cycle.
`define SMI_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/smi_pkg.sv =====
// Package: types, constants and helpers for the small matrix inverse block.
`default_nettype none
package smi_pkg;
    localparam int MAX_ORDER_DEF = 3;
    localparam int ELEM_W = 16;
    localparam int COF_W = 34;
    localparam int DET_W = 50;
    localparam int RES_W = 32;
    // quotient bits: 2^24*|cof| up to 2^57; the divider yields enough bits to see overflow
    localparam int QB = 34;
    localparam int NUM_W = COF_W + 24 + 1;

    typedef struct packed {
        logic [1:0] order;
        logic signed [ELEM_W-1:0] a_r0c0;
        logic signed [ELEM_W-1:0] a_r0c1;
        logic signed [ELEM_W-1:0] a_r0c2;
        logic signed [ELEM_W-1:0] a_r1c0;
        logic signed [ELEM_W-1:0] a_r1c1;
        logic signed [ELEM_W-1:0] a_r1c2;
        logic signed [ELEM_W-1:0] a_r2c0;
        logic signed [ELEM_W-1:0] a_r2c1;
        logic signed [ELEM_W-1:0] a_r2c2;
    } in_item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] b_r0c0;
        logic signed [RES_W-1:0] b_r0c1;
        logic signed [RES_W-1:0] b_r0c2;
        logic signed [RES_W-1:0] b_r1c0;
        logic signed [RES_W-1:0] b_r1c1;
        logic signed [RES_W-1:0] b_r1c2;
        logic signed [RES_W-1:0] b_r2c0;
        logic signed [RES_W-1:0] b_r2c1;
        logic signed [RES_W-1:0] b_r2c2;
        logic singular;
    } out_item_t;
endpackage
`default_nettype wire

// ===== rtl/smi_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per stage, one division per cycle while en is high.
`default_nettype none
module smi_div_pipe #(
    parameter int NUM_W = smi_pkg::NUM_W,
    parameter int DEN_W = smi_pkg::DET_W,
    parameter int QB = smi_pkg::QB
) (
    input  wire              clk,
    input  wire              en,
    input  wire [NUM_W-1:0]  num,
    input  wire [DEN_W-1:0]  den,
    output logic [QB-1:0]    quot
);
    // num must be below den * 2^QB (caller clamps); remainder fits DEN_W+1 bits
    logic [NUM_W-1:0] num_reg [QB+1];
    logic [DEN_W:0]   rem_reg [QB+1];
    logic [DEN_W-1:0] den_reg [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];

    // high part of num is already below den; the low QB bits are shifted in
    always_comb
    begin
        num_reg[0] = {num[QB-1:0], (NUM_W-QB)'(0)};
        rem_reg[0] = (DEN_W+1)'(num[NUM_W-1:QB]);
        den_reg[0] = den;
        q_reg[0]   = '0;
    end

    genvar s;
    generate
        for (s = 0; s < QB; s++)
        begin : g_st
            logic [DEN_W+1:0] trial;
            logic [DEN_W:0] rem_next;
            logic [QB-1:0] q_next;
            always_comb
            begin
                trial = {rem_reg[s], num_reg[s][NUM_W-1]};
                if (trial >= {2'b00, den_reg[s]})
                begin
                    rem_next = (DEN_W+1)'(trial - {2'b00, den_reg[s]});
                    q_next = {q_reg[s][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DEN_W:0];
                    q_next = {q_reg[s][QB-2:0], 1'b0};
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s+1] <= rem_next;
                    q_reg[s+1]   <= q_next;
                    num_reg[s+1] <= {num_reg[s][NUM_W-2:0], 1'b0};
                    den_reg[s+1] <= den_reg[s];
                end
            end
        end
    endgenerate

    assign quot = q_reg[QB];
endmodule
`default_nettype wire

// ===== rtl/small_matrix_inverse_top.sv =====
// Small matrix inverse (order 1 to 3) by adjugate over determinant.
// in_valid/in_ready/in_item carry one matrix item; out_valid/out_ready/out_item
// carry its inverse. One item can enter every cycle while the output is not stalled.
// Each item passes through registers for inputs, products, cofactor sums,
// determinant products and sum, then scaling feeds a QB-stage bit-serial divider
// array in parallel for all nine entries, then saturation and output. The whole
// pipeline advances together; when out_ready is low and the output stage
// holds an item, every stage freezes and in_ready drops, so nothing is lost
// or repeated. Reset clears all valid bits; data registers are not reset.
// Singular or out-of-range order gives singular=1 and zero elements.
// Positions outside the order's corner are zero.
`default_nettype none
`include "small_matrix_inverse_top_assert.svh"
module small_matrix_inverse_top #(
    parameter int MAX_ORDER = smi_pkg::MAX_ORDER_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire smi_pkg::in_item_t in_item,
    output logic              out_valid,
    input  wire               out_ready,
    output smi_pkg::out_item_t out_item
);
    localparam int EW = smi_pkg::ELEM_W;
    localparam int CW = smi_pkg::COF_W;
    localparam int DW = smi_pkg::DET_W;
    localparam int QB = smi_pkg::QB;
    localparam int NW = smi_pkg::NUM_W;
    localparam int PW = 2 * EW;
    localparam int NST = 6 + QB;

    logic adv;
    logic [NST-1:0] v_reg;
    assign adv = !v_reg[NST-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NST-2:0], in_valid};
    end

    // stage 1: register inputs as an array
    logic signed [EW-1:0] a_reg [9];
    logic [1:0] n1_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg[0] <= in_item.a_r0c0; a_reg[1] <= in_item.a_r0c1;
            a_reg[2] <= in_item.a_r0c2; a_reg[3] <= in_item.a_r1c0;
            a_reg[4] <= in_item.a_r1c1; a_reg[5] <= in_item.a_r1c2;
            a_reg[6] <= in_item.a_r2c0; a_reg[7] <= in_item.a_r2c1;
            a_reg[8] <= in_item.a_r2c2; n1_reg <= in_item.order;
        end
    end

    // stage 2: 18 pairwise products for the 3x3 cofactors
    localparam int PA [18] = '{4,5, 2,1, 1,2, 5,3, 0,2, 2,0, 3,4, 1,0, 0,1};
    localparam int PB [18] = '{8,7, 7,8, 5,4, 6,8, 8,6, 3,5, 7,6, 6,7, 4,3};
    logic signed [PW-1:0] p_reg [18];
    logic signed [EW-1:0] a2_reg [9];
    logic [1:0] n2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 18; i++)
                p_reg[i] <= a_reg[PA[i]] * a_reg[PB[i]];
            a2_reg <= a_reg;
            n2_reg <= n1_reg;
        end
    end

    // stage 3: cofactors, chosen by order
    logic signed [CW-1:0] cof_reg [9];
    logic signed [CW-1:0] cof_next [9];
    logic signed [EW-1:0] a3_reg [3];
    logic [1:0] n3_reg;
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            cof_next[i] = CW'(p_reg[2*i]) - CW'(p_reg[2*i+1]);
        if (n2_reg == 2'd1)
        begin
            for (int i = 0; i < 9; i++)
                cof_next[i] = '0;
            cof_next[0] = CW'(1);
        end
        else if (n2_reg == 2'd2)
        begin
            for (int i = 0; i < 9; i++)
                cof_next[i] = '0;
            cof_next[0] = CW'(a2_reg[4]);
            cof_next[1] = -CW'(a2_reg[1]);
            cof_next[3] = -CW'(a2_reg[3]);
            cof_next[4] = CW'(a2_reg[0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cof_reg <= cof_next;
            a3_reg[0] <= a2_reg[0]; a3_reg[1] <= a2_reg[1]; a3_reg[2] <= a2_reg[2];
            n3_reg <= n2_reg;
        end
    end

    // stage 4: determinant terms (first row times first column of adjugate)
    logic signed [DW-1:0] dt_reg [3];
    logic signed [CW-1:0] cof4_reg [9];
    logic [1:0] n4_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (n3_reg == 2'd1)
            begin
                dt_reg[0] <= DW'(a3_reg[0]); dt_reg[1] <= '0; dt_reg[2] <= '0;
            end
            else
            begin
                dt_reg[0] <= DW'(a3_reg[0] * cof_reg[0]);
                dt_reg[1] <= DW'(a3_reg[1] * cof_reg[3]);
                dt_reg[2] <= (n3_reg == 2'd3) ? DW'(a3_reg[2] * cof_reg[6]) : '0;
            end
            cof4_reg <= cof_reg;
            n4_reg <= n3_reg;
        end
    end

    // stage 5: determinant, singular flag
    logic signed [DW-1:0] det_reg;
    logic sing5_reg;
    logic signed [CW-1:0] cof5_reg [9];
    logic signed [DW-1:0] det_sum;
    assign det_sum = dt_reg[0] + dt_reg[1] + dt_reg[2];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_reg <= det_sum;
            sing5_reg <= (det_sum == '0) || (n4_reg == 2'd0) || (32'(n4_reg) > MAX_ORDER);
            cof5_reg <= cof4_reg;
        end
    end

    // stage 6: magnitudes, rounding numerator 2*|cof|*2^24 + |det|, den 2*|det|
    logic [DW-1:0] dmag;
    assign dmag = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
    logic [NW-1:0] num6 [9];
    logic [QB-1:0] sing_pipe;
    logic [8:0] neg6;
    logic [8:0] zero6;
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            logic [CW-1:0] cm;
            logic [NW:0] t;
            logic [DW+QB:0] lim;
            cm = cof5_reg[i][CW-1] ? CW'(-cof5_reg[i]) : CW'(cof5_reg[i]);
            t = ({(NW+1-CW)'(0), cm} << 25) + (NW+1)'(dmag);
            // keep the quotient within QB bits; a quotient of 2^(QB-1) saturates anyway
            lim = {dmag, (QB+1)'(0)};
            num6[i] = ({(DW+QB-NW)'(0), t} >= lim) ? NW'({dmag, QB'(0)}) : NW'(t);
            neg6[i] = cof5_reg[i][CW-1] ^ det_reg[DW-1];
            zero6[i] = (cof5_reg[i] == '0);
        end
    end

    logic [QB-1:0] q [9];
    genvar g;
    generate
        for (g = 0; g < 9; g++)
        begin : g_div
            smi_div_pipe #(.NUM_W(NW), .DEN_W(DW+1), .QB(QB)) u_div (
                .clk(clk), .en(adv), .num(num6[g]), .den({dmag, 1'b0}), .quot(q[g])
            );
        end
    endgenerate

    logic [8:0] neg_p_reg [QB];
    logic [8:0] zero_p_reg [QB];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_p_reg[0] <= neg6; zero_p_reg[0] <= zero6; sing_pipe[0] <= sing5_reg;
            for (int i = 1; i < QB; i++)
            begin
                neg_p_reg[i] <= neg_p_reg[i-1]; zero_p_reg[i] <= zero_p_reg[i-1];
                sing_pipe[i] <= sing_pipe[i-1];
            end
        end
    end

    // final stage: sign, saturate, pack
    logic signed [31:0] res [9];
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            if (sing_pipe[QB-1] || zero_p_reg[QB-1][i] || q[i] == '0)
                res[i] = '0;
            else if (neg_p_reg[QB-1][i])
                res[i] = (q[i] > QB'(33'h80000000)) ? 32'sh80000000 : -32'(q[i]);
            else
                res[i] = (q[i] > QB'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : 32'(q[i]);
        end
    end

    smi_pkg::out_item_t out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.b_r0c0 <= res[0]; out_reg.b_r0c1 <= res[1]; out_reg.b_r0c2 <= res[2];
            out_reg.b_r1c0 <= res[3]; out_reg.b_r1c1 <= res[4]; out_reg.b_r1c2 <= res[5];
            out_reg.b_r2c0 <= res[6]; out_reg.b_r2c1 <= res[7]; out_reg.b_r2c2 <= res[8];
            out_reg.singular <= sing_pipe[QB-1];
        end
    end
    assign out_item = out_reg;

    `SMI_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "not ready with empty output")
    `SMI_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "output item changed under stall")
    `SMI_ASSERT_IMP(a_singular_zero, clk, rst_n, out_valid && out_item.singular, out_item.b_r0c0 == 0 && out_item.b_r1c1 == 0 && out_item.b_r2c2 == 0, "singular item with nonzero diagonal")
endmodule
`default_nettype wire

// ===== tb/tb_small_matrix_inverse_top.sv =====
// Testbench for the small matrix inverse block: directed and random matrices, checked by a predictor.
`timescale 1ns / 1ps
module tb_small_matrix_inverse_top;
    localparam int LATENCY = 5 + smi_pkg::QB + 1;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    smi_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    smi_pkg::out_item_t out_item;

    smi_pkg::out_item_t inverse_q[$];
    int errors = 0;
    int results_seen = 0;
    int singular_seen = 0;
    int sat_seen = 0;
    int cycles = 0;
    int send_idle_pct = 10;
    int recv_idle_pct = 10;
    int hold_off = 0;
    int order_count[4];

    small_matrix_inverse_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // round(cof * 2^24 / det), ties away from zero, saturated
    function automatic logic [31:0] scaled_quotient(longint cof, longint det);
        logic neg;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        neg = (cof < 0) != (det < 0);
        num = (cof < 0 ? -cof : cof);
        num = num << 24;
        den = (det < 0 ? -det : det);
        if (den == 0)
            return '0;
        q = (2 * num + den) / (2 * den);
        if (q == 0)
            return '0;
        if (neg)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return -q[31:0];
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic smi_pkg::out_item_t invert_matrix(smi_pkg::in_item_t m);
        longint a[3][3];
        longint cf[3][3];
        longint det;
        logic [31:0] b[3][3];
        smi_pkg::out_item_t r;
        int n;
        a[0][0] = m.a_r0c0; a[0][1] = m.a_r0c1; a[0][2] = m.a_r0c2;
        a[1][0] = m.a_r1c0; a[1][1] = m.a_r1c1; a[1][2] = m.a_r1c2;
        a[2][0] = m.a_r2c0; a[2][1] = m.a_r2c1; a[2][2] = m.a_r2c2;
        n = m.order;
        r = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                cf[i][j] = 0;
                b[i][j] = '0;
            end
        det = 0;
        if (n == 1)
        begin
            det = a[0][0];
            cf[0][0] = 1;
        end
        else if (n == 2)
        begin
            det = a[0][0] * a[1][1] - a[0][1] * a[1][0];
            cf[0][0] = a[1][1];
            cf[0][1] = -a[0][1];
            cf[1][0] = -a[1][0];
            cf[1][1] = a[0][0];
        end
        else if (n == 3)
        begin
            cf[0][0] = a[1][1] * a[2][2] - a[1][2] * a[2][1];
            cf[0][1] = a[0][2] * a[2][1] - a[0][1] * a[2][2];
            cf[0][2] = a[0][1] * a[1][2] - a[0][2] * a[1][1];
            cf[1][0] = a[1][2] * a[2][0] - a[1][0] * a[2][2];
            cf[1][1] = a[0][0] * a[2][2] - a[0][2] * a[2][0];
            cf[1][2] = a[0][2] * a[1][0] - a[0][0] * a[1][2];
            cf[2][0] = a[1][0] * a[2][1] - a[1][1] * a[2][0];
            cf[2][1] = a[0][1] * a[2][0] - a[0][0] * a[2][1];
            cf[2][2] = a[0][0] * a[1][1] - a[0][1] * a[1][0];
            det = a[0][0] * cf[0][0] + a[0][1] * cf[1][0] + a[0][2] * cf[2][0];
        end
        // order zero lands here too: det stays zero
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                b[i][j] = scaled_quotient(cf[i][j], det);
        r.b_r0c0 = b[0][0]; r.b_r0c1 = b[0][1]; r.b_r0c2 = b[0][2];
        r.b_r1c0 = b[1][0]; r.b_r1c1 = b[1][1]; r.b_r1c2 = b[1][2];
        r.b_r2c0 = b[2][0]; r.b_r2c1 = b[2][1]; r.b_r2c2 = b[2][2];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= 30)
            $display("mismatch on result %0d, %s: got %h expected %h",
                     results_seen, what, got, want);
    endtask

    // valid stays high after an accept when the next item follows at once
    task automatic send_matrix(smi_pkg::in_item_t m);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= m;
        inverse_q.push_back(invert_matrix(m));
        order_count[m.order]++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // receiver side ready, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        smi_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (inverse_q.size() == 0)
            begin
                errors++;
                $display("unexpected result with nothing pending");
            end
            else
            begin
                want = inverse_q.pop_front();
                if (out_item.b_r0c0 !== want.b_r0c0)
                    report_mismatch("b_r0c0", out_item.b_r0c0, want.b_r0c0);
                if (out_item.b_r0c1 !== want.b_r0c1)
                    report_mismatch("b_r0c1", out_item.b_r0c1, want.b_r0c1);
                if (out_item.b_r0c2 !== want.b_r0c2)
                    report_mismatch("b_r0c2", out_item.b_r0c2, want.b_r0c2);
                if (out_item.b_r1c0 !== want.b_r1c0)
                    report_mismatch("b_r1c0", out_item.b_r1c0, want.b_r1c0);
                if (out_item.b_r1c1 !== want.b_r1c1)
                    report_mismatch("b_r1c1", out_item.b_r1c1, want.b_r1c1);
                if (out_item.b_r1c2 !== want.b_r1c2)
                    report_mismatch("b_r1c2", out_item.b_r1c2, want.b_r1c2);
                if (out_item.b_r2c0 !== want.b_r2c0)
                    report_mismatch("b_r2c0", out_item.b_r2c0, want.b_r2c0);
                if (out_item.b_r2c1 !== want.b_r2c1)
                    report_mismatch("b_r2c1", out_item.b_r2c1, want.b_r2c1);
                if (out_item.b_r2c2 !== want.b_r2c2)
                    report_mismatch("b_r2c2", out_item.b_r2c2, want.b_r2c2);
                if (out_item.singular !== want.singular)
                    report_mismatch("singular", out_item.singular, want.singular);
                if (want.singular)
                    singular_seen++;
                if (want.b_r0c0 == 32'h7FFF_FFFF || want.b_r0c0 == 32'h8000_0000)
                    sat_seen++;
            end
            results_seen++;
        end
    end

    function automatic smi_pkg::in_item_t make_matrix(logic [1:0] n, logic signed [15:0] e[9]);
        smi_pkg::in_item_t m;
        m.order = n;
        m.a_r0c0 = e[0]; m.a_r0c1 = e[1]; m.a_r0c2 = e[2];
        m.a_r1c0 = e[3]; m.a_r1c1 = e[4]; m.a_r1c2 = e[5];
        m.a_r2c0 = e[6]; m.a_r2c1 = e[7]; m.a_r2c2 = e[8];
        return m;
    endfunction

    // mostly small Q8.8 values so inverses stay in range, some full-range
    function automatic logic signed [15:0] random_element();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return $signed(16'($urandom_range(1024))) - 16'sd512;
        else if (pick < 60)
            return $urandom_range(3) == 0 ? 16'sh8000 : 16'sh7FFF;
        else if (pick < 70)
            return $signed(16'($urandom_range(8))) - 16'sd4;
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        logic signed [15:0] e[9];
        // identity in each order, and the unused corner filled with junk
        for (int n = 1; n <= 3; n++)
        begin
            for (int k = 0; k < 9; k++)
                e[k] = 16'sh7A5A;
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    e[i * 3 + j] = (i == j) ? 16'sh0100 : 16'sh0000;
            send_matrix(make_matrix(2'(n), e));
        end
        // order zero: always singular
        for (int k = 0; k < 9; k++)
            e[k] = 16'sh0100;
        send_matrix(make_matrix(2'd0, e));
        // zero determinant in orders 1..3
        e = '{16'sh0000, 16'sh0001, 16'sh0002, 16'sh0003, 16'sh0004,
              16'sh0005, 16'sh0006, 16'sh0007, 16'sh0008};
        send_matrix(make_matrix(2'd1, e));
        e = '{16'sh0200, 16'sh0400, 16'sh0000, 16'sh0100, 16'sh0200,
              16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
        send_matrix(make_matrix(2'd2, e));
        e = '{16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400, 16'sh0500,
              16'sh0600, 16'sh0700, 16'sh0800, 16'sh0900};
        send_matrix(make_matrix(2'd3, e));
        // near-singular order two (det of one lsb): saturates both ways
        e = '{16'sh0100, 16'sh00FF, 16'sh0000, 16'sh0101, 16'sh0100,
              16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
        send_matrix(make_matrix(2'd2, e));
        // smallest magnitudes in order one: largest inverses
        e = '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
              16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
        send_matrix(make_matrix(2'd1, e));
        e[0] = -16'sh0001;
        send_matrix(make_matrix(2'd1, e));
        // extremes of the element range
        e[0] = 16'sh8000;
        send_matrix(make_matrix(2'd1, e));
        e[0] = 16'sh7FFF;
        send_matrix(make_matrix(2'd1, e));
        for (int k = 0; k < 9; k++)
            e[k] = (k % 4 == 0) ? 16'sh7FFF : 16'sh8000;
        send_matrix(make_matrix(2'd3, e));
        for (int k = 0; k < 9; k++)
            e[k] = (k % 4 == 0) ? 16'sh8000 : 16'sh7FFF;
        send_matrix(make_matrix(2'd2, e));
        send_matrix(make_matrix(2'd3, e));
        // rounding: 1/3 style values of both signs
        e = '{16'sh0300, 16'sh0000, 16'sh0000, 16'sh0000, -16'sh0300,
              16'sh0000, 16'sh0000, 16'sh0000, 16'sh0600};
        send_matrix(make_matrix(2'd3, e));
        e[0] = 16'sh0003;
        send_matrix(make_matrix(2'd1, e));
        e = '{16'sh0002, 16'sh0003, 16'sh0000, 16'sh0004, 16'sh0007,
              16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
        send_matrix(make_matrix(2'd2, e));
    endtask

    task automatic test_random(int count);
        logic signed [15:0] e[9];
        logic [1:0] n;
        for (int t = 0; t < count; t++)
        begin
            n = ($urandom_range(19) == 0) ? 2'd0 : 2'($urandom_range(3, 1));
            for (int k = 0; k < 9; k++)
                e[k] = random_element();
            // sometimes force a singular matrix: duplicate a row
            if (n == 3 && $urandom_range(9) == 0)
            begin
                e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
            end
            send_matrix(make_matrix(n, e));
        end
    endtask

    // receiver stalls for a long time while items keep coming
    task automatic test_backpressure();
        hold_off <= 300;
        test_random(120);
    endtask

    initial
    begin
        int drain;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300);
        send_idle_pct = 10;
        recv_idle_pct = 10;
        test_backpressure();
        test_random(480);
        in_valid <= 1'b0;
        drain = 0;
        while (inverse_q.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (inverse_q.size() != 0)
        begin
            errors++;
            $display("%0d expected results never arrived", inverse_q.size());
        end
        $display("checked %0d inverses (orders 0/1/2/3: %0d/%0d/%0d/%0d)", results_seen,
                 order_count[0], order_count[1], order_count[2], order_count[3]);
        $display("%0d singular, %0d saturated corner elements, %0d errors",
                 singular_seen, sat_seen, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/smi_pkg.sv
rtl/smi_div_pipe.sv
rtl/small_matrix_inverse_top.sv
tb/tb_small_matrix_inverse_top.sv
